// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the readability block's modules.
// Depends on nothing; each user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clr_pkg.sv =====
// Package for the Coleman-Liau readability block: widths, coefficients,
// character codes and the back-end state type. Depends on nothing.
package clr_pkg;

  // Default counter width.
  localparam int DEF_COUNT_BITS = 16;

  // Result field widths.
  localparam int RAW_W  = 22;
  localparam int BAND_W = 5;
  localparam int LTOT_W = 16;
  localparam int WTOT_W = 17;
  localparam int STOT_W = 16;

  // Coefficients scaled by 100: index is 588*L - 2960*S - 1580*W over 100*W.
  localparam int COEF_LETTER = 588;
  localparam int COEF_MARK   = 2960;
  localparam int COEF_WORD   = 1580;
  localparam int COEF_DEN    = 100;

  // Top grade band.
  localparam int BAND_MAX = 16;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/core/clr_front.sv =====
// Front end: classifies text bytes and keeps saturating counters.
// Depends on clr_pkg; hands a count snapshot to the queue on the final byte.
`include "assert_macros.svh"

module clr_front #(
  parameter int COUNT_BITS = clr_pkg::DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_text_byte,
  input  logic                    in_end_of_text,
  input  logic                    push_ready,
  output logic                    push_valid,
  output logic [3*COUNT_BITS-1:0] push_data
);
  import clr_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] letters_r, letters_nxt;
  logic [COUNT_BITS-1:0] spaces_r, spaces_nxt;
  logic [COUNT_BITS-1:0] marks_r, marks_nxt;
  logic                  is_letter, is_space, is_mark;
  logic                  accept;

  // Bytes are taken whenever the queue has room for a snapshot.
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Classify the incoming character.
  always_comb begin
    is_letter = in_text_byte inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
    is_space  = (in_text_byte == CH_SPACE);
    is_mark   = in_text_byte inside {CH_DOT, CH_BANG, CH_QUEST};
  end

  // Saturating counts including the current beat.
  always_comb begin
    letters_nxt = letters_r;
    spaces_nxt  = spaces_r;
    marks_nxt   = marks_r;
    if (is_letter && letters_r != CNT_MAX) begin
      letters_nxt = letters_r + 1'b1;
    end
    if (is_space && spaces_r != CNT_MAX) begin
      spaces_nxt = spaces_r + 1'b1;
    end
    if (is_mark && marks_r != CNT_MAX) begin
      marks_nxt = marks_r + 1'b1;
    end
  end

  // The final beat pushes its updated counts.
  assign push_valid = accept && in_end_of_text;
  assign push_data  = {letters_nxt, spaces_nxt, marks_nxt};

  // Counters restart after the final beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_r <= '0;
      spaces_r  <= '0;
      marks_r   <= '0;
    end else if (accept) begin
      if (in_end_of_text) begin
        letters_r <= '0;
        spaces_r  <= '0;
        marks_r   <= '0;
      end else begin
        letters_r <= letters_nxt;
        spaces_r  <= spaces_nxt;
        marks_r   <= marks_nxt;
      end
    end
  end

  `ASSERT_NEXT(a_clear_after_end, accept && in_end_of_text,
    letters_r == '0 && spaces_r == '0 && marks_r == '0, "counters not cleared after final beat")

endmodule

// ===== rtl/core/clr_queue.sv =====
// Two-entry queue of count snapshots between the front and back ends.
// Depends on clr_pkg only for the default snapshot width.
`include "assert_macros.svh"

module clr_queue #(
  parameter int WIDTH = 3 * clr_pkg::DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import clr_pkg::*;

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Snapshot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `ASSERT_CLK(a_fill_range, cnt_r != 2'd3, "queue fill count out of range")
  `ASSERT_IMPL(a_ptr_match, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r,
    "queue pointers disagree with fill count")

endmodule

// ===== rtl/core/clr_back.sv =====
// Back end: scales the counts, divides bit-serially with rounding and
// holds the result beat. Depends on clr_pkg.
`include "assert_macros.svh"

module clr_back #(
  parameter int COUNT_BITS = clr_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  logic [3*COUNT_BITS-1:0]        pop_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [clr_pkg::RAW_W-1:0]  out_raw_index,
  output logic [clr_pkg::BAND_W-1:0]     out_grade_band,
  output logic [clr_pkg::LTOT_W-1:0]     out_letter_total,
  output logic [clr_pkg::WTOT_W-1:0]     out_word_total,
  output logic [clr_pkg::STOT_W-1:0]     out_sentence_total
);
  import clr_pkg::*;

  localparam int CB   = COUNT_BITS;
  localparam int PLW  = CB + 10;   // 588 * letters
  localparam int PSW  = CB + 12;   // 2960 * marks
  localparam int PWW  = CB + 12;   // 1580 * words
  localparam int DENW = CB + 8;    // 100 * words
  localparam int NUMW = CB + 14;   // signed numerator
  localparam int MAGW = CB + 13;   // numerator magnitude
  localparam int DW   = CB + 15;   // rounded dividend, quotient width
  localparam int VW   = CB + 9;    // divisor 200 * words
  localparam int STW  = $clog2(DW + 1);

  back_state_t state_r, state_nxt;

  logic [CB-1:0]          l_r, s_r;
  logic [CB:0]            w_r;
  logic [PLW-1:0]         pl_r;
  logic [PSW-1:0]         ps_r;
  logic [PWW-1:0]         pw_r;
  logic [DENW-1:0]        den_r;
  logic                   neg_r;
  logic [VW-1:0]          div_r;
  logic [VW-1:0]          rem_r;
  logic [DW-1:0]          dq_r;
  logic [STW-1:0]         step_r;
  logic                   out_valid_r;
  logic signed [RAW_W-1:0] raw_r;
  logic [BAND_W-1:0]      band_r;
  logic [LTOT_W-1:0]      ltot_r;
  logic [WTOT_W-1:0]      wtot_r;
  logic [STOT_W-1:0]      stot_r;

  logic signed [NUMW-1:0] num;
  logic [MAGW-1:0]        mag;
  logic [VW:0]            trial;
  logic                   trial_ge;
  logic [DW:0]            idx;
  logic [BAND_W-1:0]      band;
  logic [CB+LTOT_W-1:0]   l_ext;
  logic [CB+WTOT_W:0]     w_ext;
  logic [CB+STOT_W-1:0]   s_ext;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and queue pop.
  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: state_nxt = BK_SUM;
      BK_SUM: state_nxt = BK_DIV;
      BK_DIV: begin
        if (step_r == STW'(DW - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: state_nxt = BK_DONE;
      BK_DONE: begin
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Signed numerator and its magnitude.
  always_comb begin
    num = $signed(NUMW'(pl_r)) - $signed(NUMW'(ps_r)) - $signed(NUMW'(pw_r));
    if (num[NUMW-1]) begin
      mag = MAGW'(-num);
    end else begin
      mag = MAGW'(num);
    end
  end

  // One restoring division step.
  always_comb begin
    trial    = {rem_r, dq_r[DW-1]};
    trial_ge = (trial >= {1'b0, div_r});
  end

  // Signed rounded index and its grade band.
  always_comb begin
    if (neg_r) begin
      idx = -{1'b0, dq_r};
    end else begin
      idx = {1'b0, dq_r};
    end
    if (neg_r || dq_r == '0) begin
      band = '0;
    end else if (dq_r >= DW'(BAND_MAX)) begin
      band = BAND_W'(BAND_MAX);
    end else begin
      band = dq_r[BAND_W-1:0];
    end
    l_ext = {{LTOT_W{1'b0}}, l_r};
    w_ext = {{WTOT_W{1'b0}}, w_r};
    s_ext = {{STOT_W{1'b0}}, s_r};
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          l_r <= pop_data[3*CB-1:2*CB];
          w_r <= {1'b0, pop_data[2*CB-1:CB]} + 1'b1;
          s_r <= pop_data[CB-1:0];
        end
      end
      BK_MUL: begin
        pl_r  <= PLW'(l_r) * PLW'(COEF_LETTER);
        ps_r  <= PSW'(s_r) * PSW'(COEF_MARK);
        pw_r  <= PWW'(w_r) * PWW'(COEF_WORD);
        den_r <= DENW'(w_r) * DENW'(COEF_DEN);
      end
      BK_SUM: begin
        neg_r <= num[NUMW-1];
        dq_r  <= {mag, 1'b0} + DW'(den_r);
        div_r <= {den_r, 1'b0};
        rem_r <= '0;
      end
      BK_DIV: begin
        if (trial_ge) begin
          rem_r <= VW'(trial - {1'b0, div_r});
        end else begin
          rem_r <= VW'(trial);
        end
        dq_r <= {dq_r[DW-2:0], trial_ge};
      end
      BK_FIN: begin
        raw_r  <= idx[RAW_W-1:0];
        band_r <= band;
        ltot_r <= l_ext[LTOT_W-1:0];
        wtot_r <= w_ext[WTOT_W-1:0];
        stot_r <= s_ext[STOT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Division step counter and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == BK_DIV) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
      if (state_r == BK_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_raw_index      = raw_r;
  assign out_grade_band     = band_r;
  assign out_letter_total   = ltot_r;
  assign out_word_total     = wtot_r;
  assign out_sentence_total = stot_r;

  `ASSERT_IMPL(a_valid_in_done, out_valid_r, state_r == BK_DONE,
    "result beat shown outside the done state")
  `ASSERT_IMPL(a_step_bound, state_r == BK_DIV, step_r < STW'(DW),
    "division ran past its step count")

endmodule

// ===== rtl/core/coleman_liau_readability.sv =====
// Coleman-Liau readability: one text byte per cycle while the queue has
// room for a snapshot; each result comes from the bit-serial divider
// (COUNT_BITS + 15 steps). The back end takes a new text once its result
// is taken; a two-entry queue lets the front keep taking bytes meanwhile.
// Reset (synchronous, rst_n low) clears counters, queue and sequencer.
// Depends on clr_pkg, clr_front, clr_queue and clr_back.

module coleman_liau_readability #(
  parameter int COUNT_BITS = clr_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_text_byte,
  input  logic                              in_end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [clr_pkg::RAW_W-1:0]  out_raw_index,
  output logic [clr_pkg::BAND_W-1:0]        out_grade_band,
  output logic [clr_pkg::LTOT_W-1:0]        out_letter_total,
  output logic [clr_pkg::WTOT_W-1:0]        out_word_total,
  output logic [clr_pkg::STOT_W-1:0]        out_sentence_total
);
  import clr_pkg::*;

  localparam int SNAP_W = 3 * COUNT_BITS;

  logic              push_valid, push_ready;
  logic [SNAP_W-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [SNAP_W-1:0] pop_data;

  // Byte classification and counting.
  clr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_end_of_text(in_end_of_text),
    .push_ready    (push_ready),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  // Snapshot queue between the two halves.
  clr_queue #(
    .WIDTH(SNAP_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // Index arithmetic and result register.
  clr_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_data          (pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_index     (out_raw_index),
    .out_grade_band    (out_grade_band),
    .out_letter_total  (out_letter_total),
    .out_word_total    (out_word_total),
    .out_sentence_total(out_sentence_total)
  );

endmodule
